@@ hdl/prj_pkg.sv @@
package prj_pkg;

    localparam int WORD_W    = 32;
    localparam int SQ_W      = 2 * WORD_W;
    localparam int ROOT_W    = WORD_W;
    localparam int CFG_IDX_W = 8;

    // fixed pipeline depths of the shared units
    localparam int DTMUL_LAT = 3;
    localparam int ACCEL_LAT = ROOT_W + 6;

    typedef logic signed [WORD_W-1:0] t_s32;
    typedef logic [WORD_W-1:0]        t_u32;
    typedef logic [2:0][WORD_W-1:0]   t_vec3;
    typedef logic [2:0][WORD_W-1:0]   t_mag3;
    typedef logic [2:0][SQ_W-1:0]     t_vec64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAVITY_Z       = 8'd0,
        CFG_DRAG_SCALE      = 8'd1,
        CFG_TIME_STEP       = 8'd2,
        CFG_MAX_FLIGHT_TIME = 8'd3,
        CFG_MAX_RANGE       = 8'd4
    } t_cfg_idx;

    localparam t_u32 GRAVITY_Z_RST       = 32'hFFFC_2C00;
    localparam t_u32 DRAG_SCALE_RST      = 32'd0;
    localparam t_u32 TIME_STEP_RST       = 32'd139810;
    localparam t_u32 MAX_FLIGHT_TIME_RST = 32'd83886080;
    localparam t_u32 MAX_RANGE_RST       = 32'd25600000;

    typedef struct packed {
        t_s32 pos_x;
        t_s32 pos_y;
        t_s32 pos_z;
        t_s32 vel_x;
        t_s32 vel_y;
        t_s32 vel_z;
        t_u32 elapsed_time;
        t_u32 traveled_distance;
    } t_in_item;

    typedef struct packed {
        t_s32 new_pos_x;
        t_s32 new_pos_y;
        t_s32 new_pos_z;
        t_s32 new_vel_x;
        t_s32 new_vel_y;
        t_s32 new_vel_z;
        t_u32 new_elapsed_time;
        t_u32 new_traveled_distance;
        logic expired;
    } t_out_item;

    typedef struct packed {
        t_vec3 pos;
        t_vec3 vel;
        t_u32  elapsed;
        t_u32  trav;
    } t_side_a;

    typedef struct packed {
        t_vec3 pos;
        t_vec3 vel;
        t_vec3 vm;
        t_u32  elapsed;
        t_u32  trav;
    } t_side_b;

    typedef struct packed {
        t_vec3 pos;
        t_vec3 npos;
        t_vec3 nvel;
        t_u32  elapsed;
        t_u32  trav;
    } t_stage_f;

    typedef struct packed {
        t_vec3 npos;
        t_vec3 nvel;
        t_u32  elapsed;
        t_u32  trav;
    } t_hold;

    typedef struct packed {
        t_hold hold;
        logic  ovf;
    } t_side_c;

endpackage

@@ hdl/prj_isqrt.sv @@
module prj_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic [prj_pkg::SQ_W-1:0]  i_n,
    input  logic [SIDE_W-1:0]         i_side,
    output logic                      o_vld,
    output logic [prj_pkg::ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0]         o_side
);
    import prj_pkg::*;

    logic              r_vld  [1:ROOT_W];
    logic [SQ_W-1:0]   r_rem  [1:ROOT_W];
    logic [ROOT_W-1:0] r_res  [1:ROOT_W];
    logic [SIDE_W-1:0] r_side [1:ROOT_W];

    // one result bit per stage, most significant first
    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        localparam int B = ROOT_W - 1 - j;
        logic              cur_vld;
        logic [SQ_W-1:0]   cur_rem;
        logic [ROOT_W-1:0] cur_res;
        logic [SIDE_W-1:0] cur_side;
        logic [SQ_W-1:0]   trial;
        logic              take;

        if (j == 0) begin : g_first
            assign cur_vld  = i_vld;
            assign cur_rem  = i_n;
            assign cur_res  = '0;
            assign cur_side = i_side;
        end else begin : g_next
            assign cur_vld  = r_vld[j];
            assign cur_rem  = r_rem[j];
            assign cur_res  = r_res[j];
            assign cur_side = r_side[j];
        end

        assign trial = ({{(SQ_W-ROOT_W){1'b0}}, cur_res} << (B + 1))
                     | ({{(SQ_W-1){1'b0}}, 1'b1} << (2 * B));
        assign take  = (cur_rem >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else begin
                r_vld[j+1] <= cur_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[j+1]  <= take ? (cur_rem - trial) : cur_rem;
            r_res[j+1]  <= take ? (cur_res | ({{(ROOT_W-1){1'b0}}, 1'b1} << B)) : cur_res;
            r_side[j+1] <= cur_side;
        end
    end

    assign o_vld  = r_vld[ROOT_W];
    assign o_root = r_res[ROOT_W];
    assign o_side = r_side[ROOT_W];

endmodule

@@ hdl/prj_dtmul.sv @@
module prj_dtmul #(
    parameter int LANES  = 3,
    parameter int SHIFT  = 24,
    parameter int SIDE_W = 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_vld,
    input  logic [LANES-1:0][prj_pkg::SQ_W-1:0] i_a,
    input  prj_pkg::t_u32                      i_b,
    input  logic [SIDE_W-1:0]                  i_side,
    output logic                               o_vld,
    output logic [LANES-1:0][prj_pkg::SQ_W-1:0] o_p,
    output logic [SIDE_W-1:0]                  o_side
);
    import prj_pkg::*;

    localparam int FULL_W = SQ_W + WORD_W;
    localparam logic [FULL_W-1:0] CAP = {{(FULL_W-1){1'b0}}, 1'b1} << 62;

    logic [LANES-1:0][SQ_W-1:0]   n_mag;
    logic [LANES-1:0][SQ_W-1:0]   n_sh;
    logic [LANES-1:0][SQ_W-1:0]   n_cap;

    logic                         r1_vld, r2_vld, r3_vld;
    logic [LANES-1:0]             r1_neg, r2_neg;
    logic [LANES-1:0][SQ_W-1:0]   r1_pl, r1_ph;
    logic [LANES-1:0][FULL_W-1:0] r2_full;
    logic [LANES-1:0][SQ_W-1:0]   r3_p;
    logic [SIDE_W-1:0]            r1_side, r2_side, r3_side;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_mag[l] = i_a[l][SQ_W-1] ? (~i_a[l] + 64'd1) : i_a[l];
        end
    end

    always_comb begin
        logic [FULL_W-1:0] sh;
        for (int l = 0; l < LANES; l++) begin
            sh       = r2_full[l] >> SHIFT;
            n_sh[l]  = (sh > CAP) ? CAP[SQ_W-1:0] : sh[SQ_W-1:0];
            n_cap[l] = r2_neg[l] ? (~n_sh[l] + 64'd1) : n_sh[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            r1_neg[l]  <= i_a[l][SQ_W-1];
            r1_pl[l]   <= {32'd0, n_mag[l][31:0]} * {32'd0, i_b};
            r1_ph[l]   <= {32'd0, n_mag[l][63:32]} * {32'd0, i_b};
            r2_full[l] <= {32'd0, r1_pl[l]} + {r1_ph[l], 32'd0};
            r3_p[l]    <= n_cap[l];
        end
        r2_neg  <= r1_neg;
        r1_side <= i_side;
        r2_side <= r1_side;
        r3_side <= r2_side;
    end

    assign o_vld  = r3_vld;
    assign o_p    = r3_p;
    assign o_side = r3_side;

endmodule

@@ hdl/prj_accel.sv @@
module prj_accel #(
    parameter int SIDE_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  prj_pkg::t_vec3       i_vel,
    input  prj_pkg::t_u32        i_drag,
    input  prj_pkg::t_u32        i_grav,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_vld,
    output prj_pkg::t_vec64      o_acc,
    output logic [SIDE_W-1:0]    o_side
);
    import prj_pkg::*;

    typedef struct packed {
        t_mag3             mag;
        logic [2:0]        neg;
        logic [SIDE_W-1:0] side;
    } t_root_side;

    localparam int RS_W = $bits(t_root_side);
    localparam int FULL_W = SQ_W + WORD_W;

    t_mag3             n_mag;
    logic              r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld;
    t_mag3             r1_mag;
    logic [2:0]        r1_neg;
    t_vec64            r1_sq;
    logic [SIDE_W-1:0] r1_side;
    logic [SQ_W-1:0]   r2_n;
    t_root_side        r2_rs;
    logic              rt_vld;
    logic [ROOT_W-1:0] rt_root;
    t_root_side        rt_rs;
    logic [SQ_W-1:0]   r3_k;
    t_root_side        r3_rs;
    t_vec64            r4_pl, r4_ph;
    t_root_side        r4_rs;
    t_vec64            r5_r;
    t_root_side        r5_rs;
    t_vec64            r6_acc;
    logic [SIDE_W-1:0] r6_side;
    logic [FULL_W-1:0] n_full [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_mag[l]  = i_vel[l][31] ? (~i_vel[l] + 32'd1) : i_vel[l];
            n_full[l] = {32'd0, r4_pl[l]} + {r4_ph[l], 32'd0};
        end
    end

    prj_isqrt #(.SIDE_W(RS_W)) u_speed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r2_vld),
        .i_n     (r2_n),
        .i_side  (r2_rs),
        .o_vld   (rt_vld),
        .o_root  (rt_root),
        .o_side  (rt_rs)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= rt_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r1_mag[l] <= n_mag[l];
            r1_neg[l] <= i_vel[l][31];
            r1_sq[l]  <= {32'd0, n_mag[l]} * {32'd0, n_mag[l]};
        end
        r1_side <= i_side;

        // three squares of at most 2^62 each cannot carry out of 64 bits
        r2_n       <= r1_sq[0] + r1_sq[1] + r1_sq[2];
        r2_rs.mag  <= r1_mag;
        r2_rs.neg  <= r1_neg;
        r2_rs.side <= r1_side;

        r3_k  <= {32'd0, i_drag} * {32'd0, rt_root};
        r3_rs <= rt_rs;

        for (int l = 0; l < 3; l++) begin
            r4_pl[l] <= {32'd0, r3_rs.mag[l]} * {32'd0, r3_k[31:0]};
            r4_ph[l] <= {32'd0, r3_rs.mag[l]} * {32'd0, r3_k[63:32]};
        end
        r4_rs <= r3_rs;

        for (int l = 0; l < 3; l++) begin
            r5_r[l] <= {8'd0, n_full[l][FULL_W-1:40]};
        end
        r5_rs <= r4_rs;

        // drag opposes velocity; gravity acts on Z only
        for (int l = 0; l < 3; l++) begin
            r6_acc[l] <= (r5_rs.neg[l] ? r5_r[l] : (~r5_r[l] + 64'd1))
                       + ((l == 2) ? {{32{i_grav[31]}}, i_grav} : 64'd0);
        end
        r6_side <= r5_rs.side;
    end

    assign o_vld  = r6_vld;
    assign o_acc  = r6_acc;
    assign o_side = r6_side;

endmodule

@@ hdl/projectile_rk2_drag_step.sv @@
// Channel   Direction  Signals                                Handshake
// item in   input      start, busy, i_item                    start & !busy
// result    output     o_res_valid, o_result                  one-cycle strobe
// config    input      i_cfg_valid, o_cfg_ready, i_cfg_index,  valid & ready
//                      i_cfg_data
//
// One item enters per clock while busy is low; results leave in order, after the
// pipeline formed by the three 32-stage square root units (two speeds and the
// step length), one result bit per stage, plus the multiply stages around them.
// Synchronous active-low reset clears all valid bits and loads register defaults.
// busy is high only during reset; the receiver cannot stall, so nothing backs up.
module projectile_rk2_drag_step #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  prj_pkg::t_in_item                 i_item,
    output logic                              o_res_valid,
    output prj_pkg::t_out_item                o_result,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [prj_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  prj_pkg::t_u32                     i_cfg_data
);
    import prj_pkg::*;

    localparam int SAT_BITS = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SAT_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
    localparam int LATENCY = 1 + 2 * ACCEL_LAT + 2 * DTMUL_LAT + 1 + 1 + 3 + ROOT_W + 1;

    function automatic t_u32 sat_coord(input logic signed [63:0] x);
        t_u32 y;
        if (x > SAT_HI) begin
            y = SAT_HI[31:0];
        end else if (x < SAT_LO) begin
            y = SAT_LO[31:0];
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    // configuration registers
    t_u32 r_grav, r_drag, r_dt, r_mft, r_mrange;

    logic       accept;
    logic       r_s0_vld;
    t_in_item   r_s0;
    t_vec3      s0_vel;
    t_side_a    s0_side;

    logic       a_vld;
    t_vec64     a_acc;
    t_side_a    a_side;
    logic       h_vld;
    t_vec64     h_term;
    t_side_a    h_side;
    logic       r_h_vld;
    t_side_b    r_h;

    logic       b_vld;
    t_vec64     b_acc;
    t_side_b    b_side;
    logic [5:0][SQ_W-1:0] f_in;
    logic [5:0][SQ_W-1:0] f_term;
    t_side_a    f_side_in;
    t_side_a    f_side;
    logic       f_vld;
    logic       r_f_vld;
    t_stage_f   r_f;

    logic       r_d1_vld, r_d2_vld, r_d3_vld;
    t_mag3      r_d1_mag;
    t_hold      r_d1_hold, r_d2_hold;
    t_vec64     r_d2_sq;
    logic [SQ_W-1:0] r_d3_n;
    t_side_c    r_d3_side;
    logic [WORD_W:0]   n_esum;
    logic [WORD_W:0]   n_diff [3];
    logic [SQ_W+1:0]   n_sqsum;

    logic              c_vld;
    logic [ROOT_W-1:0] c_root;
    t_side_c           c_side;
    t_u32              n_step;
    logic [WORD_W:0]   n_dsum;
    t_u32              n_dist;
    t_u32              n_elapsed;

    logic       r_out_vld;
    t_out_item  r_out;

    assign busy        = !i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav   <= GRAVITY_Z_RST;
            r_drag   <= DRAG_SCALE_RST;
            r_dt     <= TIME_STEP_RST;
            r_mft    <= MAX_FLIGHT_TIME_RST;
            r_mrange <= MAX_RANGE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GRAVITY_Z:       r_grav   <= i_cfg_data;
                CFG_DRAG_SCALE:      r_drag   <= i_cfg_data;
                CFG_TIME_STEP:       r_dt     <= i_cfg_data;
                CFG_MAX_FLIGHT_TIME: r_mft    <= i_cfg_data;
                CFG_MAX_RANGE:       r_mrange <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld  <= 1'b0;
            r_h_vld   <= 1'b0;
            r_f_vld   <= 1'b0;
            r_d1_vld  <= 1'b0;
            r_d2_vld  <= 1'b0;
            r_d3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s0_vld  <= accept;
            r_h_vld   <= h_vld;
            r_f_vld   <= f_vld;
            r_d1_vld  <= r_f_vld;
            r_d2_vld  <= r_d1_vld;
            r_d3_vld  <= r_d2_vld;
            r_out_vld <= c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0 <= i_item;
    end

    always_comb begin
        s0_vel          = {r_s0.vel_z, r_s0.vel_y, r_s0.vel_x};
        s0_side.pos     = {r_s0.pos_z, r_s0.pos_y, r_s0.pos_x};
        s0_side.vel     = s0_vel;
        s0_side.elapsed = r_s0.elapsed_time;
        s0_side.trav    = r_s0.traveled_distance;
    end

    // acceleration at the start velocity
    prj_accel #(.SIDE_W($bits(t_side_a))) u_accel_start (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s0_vld),
        .i_vel   (s0_vel),
        .i_drag  (r_drag),
        .i_grav  (r_grav),
        .i_side  (s0_side),
        .o_vld   (a_vld),
        .o_acc   (a_acc),
        .o_side  (a_side)
    );

    // half step
    prj_dtmul #(.LANES(3), .SHIFT(25), .SIDE_W($bits(t_side_a))) u_half_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (a_vld),
        .i_a     (a_acc),
        .i_b     (r_dt),
        .i_side  (a_side),
        .o_vld   (h_vld),
        .o_p     (h_term),
        .o_side  (h_side)
    );

    always_ff @(posedge i_clk) begin
        r_h.pos     <= h_side.pos;
        r_h.vel     <= h_side.vel;
        r_h.elapsed <= h_side.elapsed;
        r_h.trav    <= h_side.trav;
        for (int l = 0; l < 3; l++) begin
            r_h.vm[l] <= sat_coord($signed({{32{h_side.vel[l][31]}}, h_side.vel[l]})
                                   + $signed(h_term[l]));
        end
    end

    // acceleration at the midpoint velocity
    prj_accel #(.SIDE_W($bits(t_side_b))) u_accel_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_h_vld),
        .i_vel   (r_h.vm),
        .i_drag  (r_drag),
        .i_grav  (r_grav),
        .i_side  (r_h),
        .o_vld   (b_vld),
        .o_acc   (b_acc),
        .o_side  (b_side)
    );

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            f_in[l]     = {{32{b_side.vm[l][31]}}, b_side.vm[l]};
            f_in[l + 3] = b_acc[l];
        end
        f_side_in.pos     = b_side.pos;
        f_side_in.vel     = b_side.vel;
        f_side_in.elapsed = b_side.elapsed;
        f_side_in.trav    = b_side.trav;
    end

    // full step: lanes 0..2 move position, lanes 3..5 move velocity
    prj_dtmul #(.LANES(6), .SHIFT(24), .SIDE_W($bits(t_side_a))) u_full_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (b_vld),
        .i_a     (f_in),
        .i_b     (r_dt),
        .i_side  (f_side_in),
        .o_vld   (f_vld),
        .o_p     (f_term),
        .o_side  (f_side)
    );

    always_ff @(posedge i_clk) begin
        r_f.pos     <= f_side.pos;
        r_f.elapsed <= f_side.elapsed;
        r_f.trav    <= f_side.trav;
        for (int l = 0; l < 3; l++) begin
            r_f.npos[l] <= sat_coord($signed({{32{f_side.pos[l][31]}}, f_side.pos[l]})
                                     + $signed(f_term[l]));
            r_f.nvel[l] <= sat_coord($signed({{32{f_side.vel[l][31]}}, f_side.vel[l]})
                                     + $signed(f_term[l + 3]));
        end
    end

    always_comb begin
        n_esum = {1'b0, r_f.elapsed} + {1'b0, r_dt};
        for (int l = 0; l < 3; l++) begin
            n_diff[l] = {r_f.npos[l][31], r_f.npos[l]} - {r_f.pos[l][31], r_f.pos[l]};
        end
        n_sqsum = {2'b00, r_d2_sq[0]} + {2'b00, r_d2_sq[1]} + {2'b00, r_d2_sq[2]};
    end

    // step length: |new_pos - pos|, squared and summed
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_d1_mag[l] <= n_diff[l][WORD_W] ? (~n_diff[l][WORD_W-1:0] + 32'd1)
                                             : n_diff[l][WORD_W-1:0];
        end
        r_d1_hold.npos    <= r_f.npos;
        r_d1_hold.nvel    <= r_f.nvel;
        r_d1_hold.elapsed <= n_esum[WORD_W] ? '1 : n_esum[WORD_W-1:0];
        r_d1_hold.trav    <= r_f.trav;

        for (int l = 0; l < 3; l++) begin
            r_d2_sq[l] <= {32'd0, r_d1_mag[l]} * {32'd0, r_d1_mag[l]};
        end
        r_d2_hold <= r_d1_hold;

        r_d3_n         <= n_sqsum[SQ_W-1:0];
        r_d3_side.hold <= r_d2_hold;
        r_d3_side.ovf  <= (n_sqsum[SQ_W+1:SQ_W] != 2'b00);
    end

    prj_isqrt #(.SIDE_W($bits(t_side_c))) u_step_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_d3_vld),
        .i_n     (r_d3_n),
        .i_side  (r_d3_side),
        .o_vld   (c_vld),
        .o_root  (c_root),
        .o_side  (c_side)
    );

    always_comb begin
        n_step    = c_side.ovf ? '1 : c_root;
        n_dsum    = {1'b0, c_side.hold.trav} + {1'b0, n_step};
        n_dist    = n_dsum[WORD_W] ? '1 : n_dsum[WORD_W-1:0];
        n_elapsed = c_side.hold.elapsed;
    end

    always_ff @(posedge i_clk) begin
        r_out.new_pos_x             <= c_side.hold.npos[0];
        r_out.new_pos_y             <= c_side.hold.npos[1];
        r_out.new_pos_z             <= c_side.hold.npos[2];
        r_out.new_vel_x             <= c_side.hold.nvel[0];
        r_out.new_vel_y             <= c_side.hold.nvel[1];
        r_out.new_vel_z             <= c_side.hold.nvel[2];
        r_out.new_elapsed_time      <= n_elapsed;
        r_out.new_traveled_distance <= n_dist;
        r_out.expired               <= (n_elapsed >= r_mft) || (n_dist >= r_mrange);
    end

    assign o_res_valid = r_out_vld;
    assign o_result    = r_out;

    a_fixed_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_res_valid)
        else $error("accepted item did not produce a result on time");

    a_no_spurious : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(accept, LATENCY))
        else $error("result without a matching accepted item");

    a_totals_grow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |->
            (o_result.new_traveled_distance >= $past(i_item.traveled_distance, LATENCY))
            && (o_result.new_elapsed_time >= $past(i_item.elapsed_time, LATENCY)))
        else $error("elapsed time or distance decreased");

endmodule
